// ===== design/pfrc_pkg.sv =====
// Package with the pixel format codes, conversion constants and the clamp function.
package pfrc_pkg;

  localparam int FMT_W = 3;
  localparam int SUM_W = 27;

  typedef enum logic [FMT_W-1:0] {
    FMT_PLANAR = 3'd0,
    FMT_PACKED = 3'd1,
    FMT_RGB24  = 3'd2,
    FMT_RGB555 = 3'd3,
    FMT_RGB565 = 3'd4
  } fmt_t;

  localparam logic signed [SUM_W-1:0] K_Y  = 27'sd76309;
  localparam logic signed [SUM_W-1:0] K_RV = 27'sd104597;
  localparam logic signed [SUM_W-1:0] K_GU = 27'sd25675;
  localparam logic signed [SUM_W-1:0] K_GV = 27'sd53279;
  localparam logic signed [SUM_W-1:0] K_BU = 27'sd132201;

  localparam logic [7:0] ALPHA = 8'hFF;

  // Floor shift by 16, then saturate to one unsigned byte.
  function automatic logic [7:0] sat_byte(input logic signed [SUM_W-1:0] x);
    logic signed [SUM_W-17:0] q;
    q = x[SUM_W-1:16];
    if (q < 0) begin
      return 8'd0;
    end else if (q > 255) begin
      return 8'd255;
    end else begin
      return q[7:0];
    end
  endfunction

endpackage

// ===== design/pfrc_stream_if.sv =====
// Stream interfaces for the input items and the result items.
interface pfrc_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  luma_first;
  logic [7:0]  luma_second;
  logic [7:0]  chroma_u;
  logic [7:0]  chroma_v;
  logic [23:0] raw_first;
  logic [23:0] raw_second;

  modport source (
    output valid, luma_first, luma_second, chroma_u, chroma_v, raw_first, raw_second,
    input  ready
  );
  modport sink (
    input  valid, luma_first, luma_second, chroma_u, chroma_v, raw_first, raw_second,
    output ready
  );
endinterface

interface pfrc_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] first_pixel;
  logic [31:0] second_pixel;

  modport source (output valid, first_pixel, second_pixel, input ready);
  modport sink (input valid, first_pixel, second_pixel, output ready);
endinterface

// ===== design/pfrc_pixel_conv.sv =====
// Combinational conversion of one pixel to an RGBA word for the selected format.
module pfrc_pixel_conv (
  input  pfrc_pkg::fmt_t fmt,
  input  logic [7:0]     luma,
  input  logic [7:0]     chroma_u,
  input  logic [7:0]     chroma_v,
  input  logic [23:0]    raw,
  output logic [31:0]    pixel
);
  import pfrc_pkg::*;

  logic signed [8:0]       dy;
  logic signed [8:0]       du;
  logic signed [8:0]       dv;
  logic signed [SUM_W-1:0] y_term;
  logic signed [SUM_W-1:0] r_sum;
  logic signed [SUM_W-1:0] g_sum;
  logic signed [SUM_W-1:0] b_sum;
  logic [7:0]              r;
  logic [7:0]              g;
  logic [7:0]              b;
  logic [15:0]             w;

  assign dy = $signed({1'b0, luma}) - 9'sd16;
  assign du = $signed({1'b0, chroma_u}) - 9'sd128;
  assign dv = $signed({1'b0, chroma_v}) - 9'sd128;

  assign y_term = K_Y * SUM_W'(dy);
  assign r_sum  = y_term + K_RV * SUM_W'(dv);
  assign g_sum  = y_term - K_GU * SUM_W'(du) - K_GV * SUM_W'(dv);
  assign b_sum  = y_term + K_BU * SUM_W'(du);

  assign r = sat_byte(r_sum);
  assign g = sat_byte(g_sum);
  assign b = sat_byte(b_sum);
  assign w = raw[15:0];

  always_comb begin
    unique case (fmt)
      FMT_PLANAR: pixel = {ALPHA, b, g, r};
      FMT_PACKED: pixel = {ALPHA, r, g, b};
      FMT_RGB24:  pixel = {ALPHA, raw};
      FMT_RGB555: pixel = {ALPHA, w[14:10], 3'b000, w[9:5], 3'b000, w[4:0], 3'b000};
      FMT_RGB565: pixel = {ALPHA, w[15:11], 3'b000, w[10:5], 2'b00, w[4:0], 3'b000};
      default:    pixel = 32'd0;
    endcase
  end

endmodule

// ===== design/pixel_format_to_rgba_converter_core.sv =====
// Top level of the pixel format to RGBA converter.
// The accepted input item is held in the input register; the conversion
// result is loaded into the result register once that register can advance.
// Throughput: one item per cycle unless stalled; an input register feeds the
// conversion logic, whose output is held in the result register until taken.
// Reset clears both valid flags and sets the format register to planar YUV.
module pixel_format_to_rgba_converter_core (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_wr_en,
  input  logic [pfrc_pkg::FMT_W-1:0]   cfg_wr_data,
  pfrc_in_if.sink                      in_item,
  pfrc_out_if.source                   out_item
);
  import pfrc_pkg::*;

  logic [FMT_W-1:0] pixel_format;
  fmt_t             fmt;

  logic        s1_valid;
  logic [7:0]  s1_luma_first;
  logic [7:0]  s1_luma_second;
  logic [7:0]  s1_chroma_u;
  logic [7:0]  s1_chroma_v;
  logic [23:0] s1_raw_first;
  logic [23:0] s1_raw_second;

  logic        out_valid;
  logic [31:0] first_pixel;
  logic [31:0] second_pixel;
  logic [31:0] first_pixel_next;
  logic [31:0] second_pixel_next;

  logic out_advance;
  logic in_ready;

  assign fmt         = fmt_t'(pixel_format);
  assign out_advance = !out_valid || out_item.ready;
  assign in_ready    = !s1_valid || out_advance;

  assign in_item.ready         = in_ready;
  assign out_item.valid        = out_valid;
  assign out_item.first_pixel  = first_pixel;
  assign out_item.second_pixel = second_pixel;

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_format <= FMT_W'(FMT_PLANAR);
    end else if (cfg_wr_en) begin
      pixel_format <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_item.valid) begin
      s1_luma_first  <= in_item.luma_first;
      s1_luma_second <= in_item.luma_second;
      s1_chroma_u    <= in_item.chroma_u;
      s1_chroma_v    <= in_item.chroma_v;
      s1_raw_first   <= in_item.raw_first;
      s1_raw_second  <= in_item.raw_second;
    end
  end

  pfrc_pixel_conv u_conv_first (
    .fmt      (fmt),
    .luma     (s1_luma_first),
    .chroma_u (s1_chroma_u),
    .chroma_v (s1_chroma_v),
    .raw      (s1_raw_first),
    .pixel    (first_pixel_next)
  );

  pfrc_pixel_conv u_conv_second (
    .fmt      (fmt),
    .luma     (s1_luma_second),
    .chroma_u (s1_chroma_u),
    .chroma_v (s1_chroma_v),
    .raw      (s1_raw_second),
    .pixel    (second_pixel_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_advance) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_advance && s1_valid) begin
      first_pixel  <= first_pixel_next;
      second_pixel <= second_pixel_next;
    end
  end

endmodule

// ===== design/pfrc_checker.sv =====
// Port-level checker for the converter core and its bind statement.
module pfrc_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] first_pixel,
  input logic [31:0] second_pixel
);

  // A result that is not taken stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(first_pixel) && $stable(second_pixel))
    else $error("Stalled result item changed or was dropped.");

  // Reset leaves no result item on the output.
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("Result item valid right after reset.");

  // With the result register empty, the block always takes a new item.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("Input not ready although the output is empty.");

  // Both words of one item carry the same alpha, which is opaque or zero.
  a_alpha: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (first_pixel[31:24] == second_pixel[31:24]) &&
                  (first_pixel[31:24] == 8'hFF || first_pixel[31:24] == 8'h00))
    else $error("Alpha bytes of a result item are inconsistent.");

endmodule

bind pixel_format_to_rgba_converter_core pfrc_checker u_pfrc_checker (
  .clk          (clk),
  .rst          (rst),
  .in_ready     (in_item.ready),
  .out_valid    (out_item.valid),
  .out_ready    (out_item.ready),
  .first_pixel  (out_item.first_pixel),
  .second_pixel (out_item.second_pixel)
);
